// ----- hw/rtl/wbps_pkg.sv -----
// ----------------------------------------------------------------------------
// wbps_pkg
// Shared types and register codes for the wildcard byte pattern search unit.
// ----------------------------------------------------------------------------
`default_nettype none

package wbps_pkg;

	localparam int unsigned IDX_W        = 20;
	localparam int unsigned CFG_DATA_W   = 64;
	localparam int unsigned CFG_IDX_W    = 3;
	localparam int unsigned NUM_PAT_REGS = 6;
	localparam int unsigned PAT_BYTES    = 8 * NUM_PAT_REGS;

	// Register indexes on the configuration port.
	localparam logic [CFG_IDX_W-1:0] REG_PAT_0_7   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PAT_8_15  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PAT_16_23 = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_PAT_24_31 = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_PAT_32_39 = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_PAT_40_47 = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_LENGTH    = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_WILD      = 3'd7;

	typedef struct packed {
		logic             last_byte;
		logic [IDX_W-1:0] byte_index;
		logic [7:0]       data_byte;
	} step_t;

	typedef struct packed {
		logic             found;
		logic [IDX_W-1:0] match_index;
	} result_t;

endpackage

`default_nettype wire

// ----- hw/rtl/wbps_cfg.sv -----
// ----------------------------------------------------------------------------
// wbps_cfg
// Configuration registers and the right-aligned compare pattern derived from
// them, so the per-byte compare sees a fixed lane-to-lane layout.
// ----------------------------------------------------------------------------
`default_nettype none

module wbps_cfg #(
	parameter int unsigned MAX_PATTERN = 48,
	parameter int unsigned LEN_W       = 6
) (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  wr_en,
	input  wire logic [wbps_pkg::CFG_IDX_W-1:0]        wr_index,
	input  wire logic [wbps_pkg::CFG_DATA_W-1:0]       wr_data,
	output logic      [MAX_PATTERN*8-1:0]              aligned,
	output logic      [MAX_PATTERN-1:0]                care,
	output logic      [LEN_W-1:0]                      len
);

	logic [wbps_pkg::NUM_PAT_REGS-1:0][wbps_pkg::CFG_DATA_W-1:0] pat_q;
	logic [5:0]                 len_raw_q;
	logic [7:0]                 wild_q;
	logic [5:0]                 len_clamped;
	logic [LEN_W-1:0]           act_len;
	logic [LEN_W-1:0]           shamt;
	logic [MAX_PATTERN*8-1:0]   rev;
	logic [MAX_PATTERN*8-1:0]   aligned_nx;
	logic [MAX_PATTERN-1:0]     care_nx;
	logic [MAX_PATTERN*8-1:0]   aligned_q;
	logic [MAX_PATTERN-1:0]     care_q;
	logic [LEN_W-1:0]           len_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pat_q     <= '0;
			len_raw_q <= 6'd1;
			wild_q    <= 8'd0;
		end else if (wr_en) begin
			unique case (wr_index)
				wbps_pkg::REG_PAT_0_7:   pat_q[0] <= wr_data;
				wbps_pkg::REG_PAT_8_15:  pat_q[1] <= wr_data;
				wbps_pkg::REG_PAT_16_23: pat_q[2] <= wr_data;
				wbps_pkg::REG_PAT_24_31: pat_q[3] <= wr_data;
				wbps_pkg::REG_PAT_32_39: pat_q[4] <= wr_data;
				wbps_pkg::REG_PAT_40_47: pat_q[5] <= wr_data;
				wbps_pkg::REG_LENGTH:    len_raw_q <= wr_data[5:0];
				wbps_pkg::REG_WILD:      wild_q <= wr_data[7:0];
				default: ;
			endcase
		end
	end

	// A length of zero behaves as one, and anything beyond the window as the
	// full window.
	always_comb begin
		if (len_raw_q == 6'd0) begin
			len_clamped = 6'd1;
		end else if (len_raw_q > 6'(MAX_PATTERN)) begin
			len_clamped = 6'(MAX_PATTERN);
		end else begin
			len_clamped = len_raw_q;
		end
		act_len = LEN_W'(len_clamped);
		shamt   = LEN_W'(MAX_PATTERN) - act_len;
	end

	// Pattern byte j must meet window lane len-1-j. Reversing the pattern and
	// shifting it down by the unused byte count puts it in exactly that place.
	always_comb begin
		for (int b = 0; b < MAX_PATTERN; b++) begin
			rev[8*b +: 8] = pat_q[(MAX_PATTERN-1-b) / 8][8*((MAX_PATTERN-1-b) % 8) +: 8];
		end
		aligned_nx = rev >> {shamt, 3'b000};
		for (int i = 0; i < MAX_PATTERN; i++) begin
			care_nx[i] = (LEN_W'(i) < act_len) && (aligned_nx[8*i +: 8] != wild_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			aligned_q <= '0;
			care_q    <= '0;
			len_q     <= LEN_W'(1);
		end else begin
			aligned_q <= aligned_nx;
			care_q    <= care_nx;
			len_q     <= act_len;
		end
	end

	assign aligned = aligned_q;
	assign care    = care_q;
	assign len     = len_q;

endmodule

`default_nettype wire

// ----- hw/rtl/wbps_match.sv -----
// ----------------------------------------------------------------------------
// wbps_match
// Byte window, fill count and search state, with the parallel wildcard
// compare of the window against the aligned pattern.
// ----------------------------------------------------------------------------
`default_nettype none

module wbps_match #(
	parameter int unsigned MAX_PATTERN = 48,
	parameter int unsigned LEN_W       = 6
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       step_en,
	input  wire wbps_pkg::step_t            step,
	input  wire logic [MAX_PATTERN*8-1:0]   aligned,
	input  wire logic [MAX_PATTERN-1:0]     care,
	input  wire logic [LEN_W-1:0]           len,
	output logic                            res_valid,
	output wbps_pkg::result_t               res
);

	logic [7:0]       win_q  [MAX_PATTERN];
	logic [7:0]       win_nx [MAX_PATTERN];
	logic [LEN_W-1:0] fill_q;
	logic [LEN_W-1:0] fill_nx;
	logic             done_q;
	logic             lanes_ok;
	logic             hit;

	always_comb begin
		win_nx[0] = step.data_byte;
		for (int i = 1; i < MAX_PATTERN; i++) begin
			win_nx[i] = win_q[i-1];
		end
		if (fill_q < LEN_W'(MAX_PATTERN)) begin
			fill_nx = LEN_W'(fill_q + 1'b1);
		end else begin
			fill_nx = fill_q;
		end
		lanes_ok = 1'b1;
		for (int i = 0; i < MAX_PATTERN; i++) begin
			if (care[i] && (aligned[8*i +: 8] != win_nx[i])) begin
				lanes_ok = 1'b0;
			end
		end
		hit = !done_q && (fill_nx >= len) && lanes_ok;
	end

	always_comb begin
		res_valid       = step_en && !done_q && (hit || step.last_byte);
		res.found       = hit;
		res.match_index = hit ?
			wbps_pkg::IDX_W'(step.byte_index - wbps_pkg::IDX_W'(len) + 1'b1) : '0;
	end

	// Window bytes need no reset: the fill count keeps stale lanes out of play.
	always_ff @(posedge clk) begin
		if (step_en && !done_q) begin
			for (int i = 0; i < MAX_PATTERN; i++) begin
				win_q[i] <= win_nx[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			done_q <= 1'b0;
		end else if (step_en) begin
			if (step.last_byte) begin
				fill_q <= '0;
				done_q <= 1'b0;
			end else if (!done_q) begin
				fill_q <= fill_nx;
				done_q <= hit;
			end
		end
	end

endmodule

`default_nettype wire

// ----- hw/rtl/wildcard_byte_pattern_search_unit.sv -----
// ----------------------------------------------------------------------------
// wildcard_byte_pattern_search_unit
// Searches a byte stream for a configured pattern with a wild byte value.
// ----------------------------------------------------------------------------
// An input beat is held in the input register, its result in the output register.
// Throughput: one byte per cycle unless the output stalls; input register, one
// compare stage, output register, with the 48-lane compare done combinationally.
// Reset clears valid flags, configuration, fill count and search state, but not
// the window or the data registers. A configuration write is registered, then
// the pattern derived from it is registered, before it takes effect.
`default_nettype none

module wildcard_byte_pattern_search_unit #(
	parameter int unsigned MAX_PATTERN = 48
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [31:0] s_tdata,   // data_byte[7:0], byte_index[27:8], zero pad
	input  wire logic        s_tlast,
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [23:0]      m_tdata,   // match_index[19:0], zero pad
	output logic             m_tuser,   // found
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [63:0] cfg_data
);

	localparam int unsigned LEN_W = $clog2(MAX_PATTERN + 1);

	logic                     valid_s1;
	wbps_pkg::step_t          step_s1;
	logic                     out_free;
	logic                     fire_s1;
	logic [MAX_PATTERN*8-1:0] aligned;
	logic [MAX_PATTERN-1:0]   care;
	logic [LEN_W-1:0]         len;
	logic                     res_valid;
	wbps_pkg::result_t        res;
	logic                     m_valid_q;
	wbps_pkg::result_t        m_res_q;

	assign cfg_ready = 1'b1;
	assign out_free  = !m_valid_q || m_tready;
	assign fire_s1   = valid_s1 && out_free;
	assign s_tready  = !valid_s1 || out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			step_s1.data_byte  <= s_tdata[7:0];
			step_s1.byte_index <= s_tdata[27:8];
			step_s1.last_byte  <= s_tlast;
		end
	end

	wbps_cfg #(
		.MAX_PATTERN (MAX_PATTERN),
		.LEN_W       (LEN_W)
	) u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid && cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.aligned  (aligned),
		.care     (care),
		.len      (len)
	);

	wbps_match #(
		.MAX_PATTERN (MAX_PATTERN),
		.LEN_W       (LEN_W)
	) u_match (
		.clk       (clk),
		.arst_n    (arst_n),
		.step_en   (fire_s1),
		.step      (step_s1),
		.aligned   (aligned),
		.care      (care),
		.len       (len),
		.res_valid (res_valid),
		.res       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (out_free) begin
			m_valid_q <= fire_s1 && res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && fire_s1 && res_valid) begin
			m_res_q <= res;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tuser  = m_res_q.found;
	assign m_tdata  = {4'd0, m_res_q.match_index};

	// A beat reporting no match always carries a zero start offset.
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tuser) |-> (m_tdata == 24'd0))
		else $error("not-found beat with non-zero match index");

	// The input side only stalls when both stages are full and the output waits.
	assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> (valid_s1 && m_tvalid && !m_tready))
		else $error("input stalled without a full pipeline");

	// A new result beat is always produced by an item held in the input stage.
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(valid_s1))
		else $error("result beat without a stepped item");

endmodule

`default_nettype wire
